/* rtl/spt_pkg.sv */
// Package with shared constants and types of the strong pseudoprime test.
package spt_pkg;
  localparam int OperandBits = 49;
  localparam int NumBases = 7;
  localparam int CountBits = 6;
  localparam logic [63:0] SptLimit = 64'd341550071728321;
  localparam logic [4:0] BaseList [NumBases] = '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17};

  typedef struct packed {
    logic start;
    logic busy;
  } mm_ctrl_t;
endpackage

/* rtl/spt_mulmod.sv */
// Bit-serial modular multiplier by double and add, one operand bit per cycle.
module spt_mulmod import spt_pkg::*; #(
  parameter int OPERAND_BITS = OperandBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [OPERAND_BITS-1:0] x_i,
  input  logic [OPERAND_BITS-1:0] y_i,
  input  logic [OPERAND_BITS-1:0] m_i,
  output logic                    busy_o,
  output logic [OPERAND_BITS-1:0] prod_o
);
  localparam int IdxBits = $clog2(OPERAND_BITS + 1);

  logic [OPERAND_BITS-1:0] acc_q, acc_d, y_q, y_d;
  logic [IdxBits-1:0]      cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic [OPERAND_BITS:0]   dbl, dbl_r, add, add_r;

  always_comb begin
    dbl    = {1'b0, acc_q} + {1'b0, acc_q};
    dbl_r  = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add    = dbl_r + {1'b0, x_i};
    add_r  = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    acc_d  = acc_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      y_d    = y_i;
      cnt_d  = IdxBits'(OPERAND_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = y_q[OPERAND_BITS-1] ? add_r[OPERAND_BITS-1:0] : dbl_r[OPERAND_BITS-1:0];
      y_d    = {y_q[OPERAND_BITS-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != IdxBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    y_q   <= y_d;
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

`ifndef SYNTHESIS
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("count not zero while idle");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("busy with zero count");
  a_acc_below_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> acc_q < m_i) else $error("product not reduced");
`endif
endmodule

/* rtl/strong_pseudoprime_test_top.sv */
// Top level of the strong pseudoprime (Miller-Rabin) primality tester.
// One candidate is tested at a time and busy stays high meanwhile. Each modular
// multiplication runs on one shared bit-serial multiplier; a full prime below
// 341550071728321 needs about seven times 2*49 products, while small,
// out-of-range and composite candidates finish sooner. The result is
// presented for one cycle with done_o and cannot be stalled by the receiver.
module strong_pseudoprime_test_top import spt_pkg::*; #(
  parameter int OPERAND_BITS = OperandBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] candidate_i,
  output logic                    done_o,
  output logic                    prime_verdict_o,
  output logic                    out_of_range_o,
  output logic [CountBits-1:0]    two_exponent_o,
  output logic [OPERAND_BITS-1:0] odd_part_o,
  output logic [CountBits-1:0]    squarings_base2_o,
  output logic [CountBits-1:0]    squarings_base3_o,
  output logic [CountBits-1:0]    squarings_base5_o,
  output logic [CountBits-1:0]    squarings_base7_o,
  output logic [CountBits-1:0]    squarings_base11_o,
  output logic [CountBits-1:0]    squarings_base13_o,
  output logic [CountBits-1:0]    squarings_base17_o
);
  localparam int BitBits = $clog2(OPERAND_BITS);
  localparam int BaseBits = $clog2(NumBases);

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_BASE, S_EXP_SQ, S_EXP_MUL, S_EXP_NEXT, S_CHECK, S_SQ, S_SQ_CHK,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [OPERAND_BITS-1:0] n_q, q_q, r_q, x_q, mx_q, my_q;
  logic [BitBits-1:0]      bit_q;
  logic [CountBits-1:0]    l_q, t_q;
  logic [BaseBits-1:0]     base_q;
  logic [CountBits-1:0]    cnt_q [NumBases];
  logic                    verdict_q, oor_q, done_q, started_q, mm_go_q;
  logic                    mm_busy;
  logic [OPERAND_BITS-1:0] mm_prod, nm1;
  mm_ctrl_t                mm;
  logic                    cand_small, cand_oor, cand_prime, mm_launch;

  assign nm1 = n_q - 1'b1;
  assign mm.start = mm_go_q;
  assign mm.busy  = mm_busy;

  assign cand_small = 64'(candidate_i) <= 64'd17;
  assign cand_oor   = !cand_small && (64'(candidate_i) >= SptLimit);

  always_comb begin
    cand_prime = 1'b0;
    for (int i = 0; i < NumBases; i++) begin
      cand_prime = cand_prime | (64'(candidate_i) == 64'(BaseList[i]));
    end
  end

  assign mm_launch = !started_q &&
                     (((state_q == S_EXP_MUL) && q_q[bit_q]) ||
                      ((state_q == S_EXP_SQ) && ((q_q >> bit_q) > OPERAND_BITS'(1))) ||
                      ((state_q == S_SQ) && (t_q < l_q)));

  spt_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_mm (
    .clk_i, .rst_ni, .start_i(mm.start), .x_i(mx_q), .y_i(my_q), .m_i(n_q),
    .busy_o(mm_busy), .prod_o(mm_prod)
  );

  logic mm_done;
  assign mm_done = started_q && !mm.busy && !mm.start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      mm_go_q   <= 1'b0;
      started_q <= 1'b0;
      verdict_q <= 1'b0;
      oor_q     <= 1'b0;
      n_q <= '0; r_q <= '0; x_q <= '0; mx_q <= '0; my_q <= '0;
      l_q <= '0; q_q <= '0; t_q <= '0; base_q <= '0; bit_q <= '0;
      for (int i = 0; i < NumBases; i++) cnt_q[i] <= '0;
    end else begin
      done_q  <= (state_q == S_DONE);
      mm_go_q <= mm_launch;
      unique case (state_q)
        S_IDLE: if (start) begin
          n_q <= candidate_i;
          verdict_q <= cand_prime;
          oor_q <= cand_oor;
          l_q <= '0;
          base_q <= '0;
          for (int i = 0; i < NumBases; i++) cnt_q[i] <= '0;
          q_q <= (cand_small || cand_oor) ? '0 : candidate_i - 1'b1;
          state_q <= (cand_small || cand_oor) ? S_DONE : S_SPLIT;
        end
        S_SPLIT: begin
          if (q_q[0]) state_q <= S_BASE;
          else begin
            q_q <= q_q >> 1;
            l_q <= l_q + 1'b1;
          end
        end
        S_BASE: begin
          r_q <= OPERAND_BITS'(1);
          x_q <= OPERAND_BITS'(BaseList[base_q]);
          bit_q <= '0;
          state_q <= S_EXP_MUL;
        end
        S_EXP_MUL: begin
          if (mm_launch) begin
            mx_q <= r_q; my_q <= x_q; started_q <= 1'b1;
          end else if (!started_q) state_q <= S_EXP_SQ;
          else if (mm_done) begin
            r_q <= mm_prod; started_q <= 1'b0; state_q <= S_EXP_SQ;
          end
        end
        S_EXP_SQ: begin
          if ((q_q >> bit_q) <= OPERAND_BITS'(1)) state_q <= S_CHECK;
          else if (mm_launch) begin
            mx_q <= x_q; my_q <= x_q; started_q <= 1'b1;
          end else if (mm_done) begin
            x_q <= mm_prod; started_q <= 1'b0; state_q <= S_EXP_NEXT;
          end
        end
        S_EXP_NEXT: begin
          bit_q <= bit_q + 1'b1;
          state_q <= S_EXP_MUL;
        end
        S_CHECK: begin
          t_q <= CountBits'(1);
          if (r_q == OPERAND_BITS'(1) || r_q == nm1) state_q <= S_SQ_CHK;
          else state_q <= S_SQ;
        end
        S_SQ: begin
          if (t_q >= l_q) state_q <= S_DONE;
          else if (mm_launch) begin
            mx_q <= r_q; my_q <= r_q; started_q <= 1'b1;
          end else if (mm_done) begin
            started_q <= 1'b0;
            r_q <= mm_prod;
            if (mm_prod == nm1) begin
              cnt_q[base_q] <= t_q;
              state_q <= S_SQ_CHK;
            end else t_q <= t_q + 1'b1;
          end
        end
        S_SQ_CHK: begin
          if (base_q == BaseBits'(NumBases - 1)) begin
            verdict_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            base_q <= base_q + 1'b1;
            state_q <= S_BASE;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign prime_verdict_o = verdict_q;
  assign out_of_range_o = oor_q;
  assign two_exponent_o = l_q;
  assign odd_part_o = q_q;
  assign squarings_base2_o  = cnt_q[0];
  assign squarings_base3_o  = cnt_q[1];
  assign squarings_base5_o  = cnt_q[2];
  assign squarings_base7_o  = cnt_q[3];
  assign squarings_base11_o = cnt_q[4];
  assign squarings_base13_o = cnt_q[5];
  assign squarings_base17_o = cnt_q[6];

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result outside idle");
  a_oor_no_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && oor_q |-> !verdict_q) else $error("out of range marked prime");
  a_go_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_go_q |=> !mm_go_q) else $error("multiplier restarted");
`endif
endmodule
